// ===== rtl/encoded_value_byte_encoder_macros.svh =====
// ----------------------------------------------------------------------------
// Encoded value byte encoder: assertion macros
// Concurrent assertion shorthands, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ENCODED_VALUE_BYTE_ENCODER_MACROS_SVH
`define ENCODED_VALUE_BYTE_ENCODER_MACROS_SVH

// Check cons in the same cycle as ante.
`define EVBE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define EVBE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/evbe_pkg.sv =====
// ----------------------------------------------------------------------------
// Encoded value byte encoder: package
// Widths, type codes and the descriptor passed from classifier to serializer.
// ----------------------------------------------------------------------------
package evbe_pkg;

  localparam int unsigned KindW  = 5;
  localparam int unsigned ValueW = 64;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned LenW   = 4;   // value byte count 0..8

  // Default depth of the descriptor queue
  localparam int unsigned DescQueueDepth = 2;

  // Value type codes
  localparam logic [KindW-1:0] KindByte       = 5'd0;
  localparam logic [KindW-1:0] KindShort      = 5'd2;
  localparam logic [KindW-1:0] KindChar       = 5'd3;
  localparam logic [KindW-1:0] KindInt        = 5'd4;
  localparam logic [KindW-1:0] KindLong       = 5'd6;
  localparam logic [KindW-1:0] KindFloat      = 5'd16;
  localparam logic [KindW-1:0] KindDouble     = 5'd17;
  localparam logic [KindW-1:0] KindIdxFirst   = 5'd21;
  localparam logic [KindW-1:0] KindIdxLast    = 5'd27;
  localparam logic [KindW-1:0] KindArray      = 5'd28;
  localparam logic [KindW-1:0] KindAnnotation = 5'd29;
  localparam logic [KindW-1:0] KindNull       = 5'd30;
  localparam logic [KindW-1:0] KindBoolean    = 5'd31;

  // One classified value: header byte, count of value bytes after it and
  // the value bytes aligned so the first one to send sits in the low byte.
  typedef struct packed {
    logic [ByteW-1:0]  header;
    logic [LenW-1:0]   nbytes;
    logic [ValueW-1:0] data;
  } desc_t;

endpackage

// ===== rtl/evbe_front.sv =====
// ----------------------------------------------------------------------------
// Encoded value byte encoder: front end
// Classifies an accepted value by kind, finds its trimmed length and builds
// the descriptor for the serializer. Unknown kinds are dropped here.
// ----------------------------------------------------------------------------
module evbe_front (
  input  logic                          accept_i,
  input  logic [evbe_pkg::KindW-1:0]    kind_i,
  input  logic [evbe_pkg::ValueW-1:0]   value_bits_i,
  output logic                          wr_valid_o,
  output evbe_pkg::desc_t               wr_desc_o
);
  import evbe_pkg::*;

  // Shortest byte count that keeps the sign of v
  function automatic logic [LenW-1:0] signed_len(logic [ValueW-1:0] v);
    logic [LenW-1:0]   n;
    logic [ValueW-1:0] s;
    n = LenW'(ValueW / ByteW);
    for (int i = ValueW / ByteW - 1; i >= 1; i--) begin
      s = ValueW'($signed(v) >>> (ByteW * i - 1));
      if (s == '0 || s == '1) n = LenW'(i);
    end
    return n;
  endfunction

  // Shortest byte count that holds v unsigned
  function automatic logic [LenW-1:0] unsigned_len(logic [ValueW-1:0] v);
    logic [LenW-1:0] n;
    n = LenW'(ValueW / ByteW);
    for (int i = ValueW / ByteW - 1; i >= 1; i--) begin
      if ((v >> (ByteW * i)) == '0) n = LenW'(i);
    end
    return n;
  endfunction

  // Index of the lowest nonzero byte, or the top byte when all are zero
  function automatic logic [LenW-2:0] float_start(logic [ValueW-1:0] v,
                                                  logic [LenW-1:0]   total);
    logic [LenW-2:0] k;
    k = (LenW-1)'(total - LenW'(1));
    for (int b = ValueW / ByteW - 1; b >= 0; b--) begin
      if (v[ByteW*b +: ByteW] != '0) k = (LenW-1)'(b);
    end
    return k;
  endfunction

  logic              keep;
  logic [ValueW-1:0] v;
  logic [LenW-1:0]   len;
  logic [LenW-2:0]   start;

  // Classify the value and trim it
  always_comb begin
    keep      = 1'b1;
    v         = value_bits_i;
    len       = LenW'(1);
    start     = '0;
    wr_desc_o = '0;
    case (kind_i)
      KindByte: begin
        v   = {{(ValueW-8){value_bits_i[7]}}, value_bits_i[7:0]};
        len = signed_len(v);
      end
      KindShort: begin
        v   = {{(ValueW-16){value_bits_i[15]}}, value_bits_i[15:0]};
        len = signed_len(v);
      end
      KindChar: begin
        v   = {{(ValueW-16){1'b0}}, value_bits_i[15:0]};
        len = unsigned_len(v);
      end
      KindInt: begin
        v   = {{(ValueW-32){value_bits_i[31]}}, value_bits_i[31:0]};
        len = signed_len(v);
      end
      KindLong: begin
        len = signed_len(v);
      end
      KindFloat: begin
        v     = {{(ValueW-32){1'b0}}, value_bits_i[31:0]};
        start = float_start(v, LenW'(4));
        len   = LenW'(4) - {1'b0, start};
      end
      KindDouble: begin
        start = float_start(v, LenW'(8));
        len   = LenW'(8) - {1'b0, start};
      end
      KindArray, KindAnnotation, KindNull: begin
        len = '0;
      end
      KindBoolean: begin
        len = '0;
      end
      default: begin
        if (kind_i inside {[KindIdxFirst:KindIdxLast]}) begin
          v   = {{(ValueW-32){1'b0}}, value_bits_i[31:0]};
          len = unsigned_len(v);
        end else begin
          keep = 1'b0;
          len  = '0;
        end
      end
    endcase

    // Build the header: argument is length minus one, or the flag bit
    if (kind_i == KindBoolean) begin
      wr_desc_o.header = {2'b00, value_bits_i[0], kind_i};
    end else if (len == '0) begin
      wr_desc_o.header = {3'b000, kind_i};
    end else begin
      wr_desc_o.header = {3'(len - LenW'(1)), kind_i};
    end
    wr_desc_o.nbytes = len;
    wr_desc_o.data   = v >> {start, 3'b000};
  end

  assign wr_valid_o = accept_i && keep;

endmodule

// ===== rtl/evbe_queue.sv =====
// ----------------------------------------------------------------------------
// Encoded value byte encoder: descriptor queue
// Small FIFO between classifier and serializer so each side stalls alone.
// ----------------------------------------------------------------------------
module evbe_queue #(
  parameter int unsigned Depth = evbe_pkg::DescQueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_valid_i,
  input  evbe_pkg::desc_t wr_desc_i,
  output logic            full_o,
  output logic            rd_valid_o,
  input  logic            rd_ready_i,
  output evbe_pkg::desc_t rd_desc_o
);
  import evbe_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  desc_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_wr, do_rd;

  assign full_o     = (count_q == CntW'(Depth));
  assign rd_valid_o = (count_q != '0);
  assign rd_desc_o  = mem_q[rd_ptr_q];
  assign do_wr      = wr_valid_i && !full_o;
  assign do_rd      = rd_ready_i && rd_valid_o;

  // Advance pointers with wrap, track occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + CntW'(1);
    end else if (do_rd && !do_wr) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the incoming descriptor
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_desc_i;
    end
  end

endmodule

// ===== rtl/evbe_back.sv =====
// ----------------------------------------------------------------------------
// Encoded value byte encoder: back end
// Serializes one descriptor into a header byte and its value bytes, one byte
// per cycle while the pop side keeps taking them, through a result register read by the pop side.
// ----------------------------------------------------------------------------
module evbe_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       rd_valid_i,
  input  evbe_pkg::desc_t            rd_desc_i,
  output logic                       rd_ready_o,
  input  logic                       pop_i,
  output logic                       empty_o,
  output logic [evbe_pkg::ByteW-1:0] out_byte_o,
  output logic                       last_byte_o
);
  import evbe_pkg::*;

  logic              out_valid_q, out_valid_d;
  logic [ByteW-1:0]  out_byte_q, out_byte_d;
  logic              out_last_q, out_last_d;
  logic              busy_q, busy_d;
  logic [ValueW-1:0] data_q, data_d;
  logic [LenW-1:0]   remain_q, remain_d;
  logic              adv;

  // Result register is free when empty or being taken
  assign adv        = !out_valid_q || pop_i;
  assign rd_ready_o = adv && !busy_q;

  always_comb begin
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    busy_d      = busy_q;
    data_d      = data_q;
    remain_d    = remain_q;
    if (adv) begin
      if (busy_q) begin
        // Send the next value byte, shift the rest down
        out_valid_d = 1'b1;
        out_byte_d  = data_q[ByteW-1:0];
        out_last_d  = (remain_q == LenW'(1));
        data_d      = data_q >> ByteW;
        remain_d    = remain_q - LenW'(1);
        busy_d      = (remain_q != LenW'(1));
      end else if (rd_valid_i) begin
        // Take a descriptor and send its header
        out_valid_d = 1'b1;
        out_byte_d  = rd_desc_i.header;
        out_last_d  = (rd_desc_i.nbytes == '0);
        data_d      = rd_desc_i.data;
        remain_d    = rd_desc_i.nbytes;
        busy_d      = (rd_desc_i.nbytes != '0);
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      busy_q      <= 1'b0;
      remain_q    <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      busy_q      <= busy_d;
      remain_q    <= remain_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
    data_q     <= data_d;
  end

  assign empty_o     = !out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_byte_o = out_last_q;

endmodule

// ===== rtl/encoded_value_byte_encoder.sv =====
// A value of n value bytes leaves as n+1 bytes (header plus 1 to 8 value
// bytes; one byte for null, boolean, array and annotation), one byte per
// cycle while pop takes them; the single byte-wide result register sets
// that rate. Values are taken on any cycle the descriptor queue has room
// and reach the result port through the descriptor queue and then the
// result register. Unknown kinds are accepted and produce no bytes.
// ----------------------------------------------------------------------------
// Encoded value byte encoder: top level
// Classifier, descriptor queue and byte serializer with queue-style ports.
// ----------------------------------------------------------------------------
module encoded_value_byte_encoder #(
  parameter int unsigned QueueDepth = evbe_pkg::DescQueueDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [evbe_pkg::KindW-1:0]    kind_i,
  input  logic [evbe_pkg::ValueW-1:0]   value_bits_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [evbe_pkg::ByteW-1:0]    out_byte_o,
  output logic                          last_byte_o
);
  import evbe_pkg::*;

  logic  accept;
  logic  wr_valid;
  desc_t wr_desc;
  logic  rd_valid;
  logic  rd_ready;
  desc_t rd_desc;

  // Accept a transaction whenever the queue has room
  assign accept = push && !full;

  evbe_front u_front (
    .accept_i     (accept),
    .kind_i       (kind_i),
    .value_bits_i (value_bits_i),
    .wr_valid_o   (wr_valid),
    .wr_desc_o    (wr_desc)
  );

  evbe_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (wr_valid),
    .wr_desc_i  (wr_desc),
    .full_o     (full),
    .rd_valid_o (rd_valid),
    .rd_ready_i (rd_ready),
    .rd_desc_o  (rd_desc)
  );

  evbe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_valid_i  (rd_valid),
    .rd_desc_i   (rd_desc),
    .rd_ready_o  (rd_ready),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_byte_o  (out_byte_o),
    .last_byte_o (last_byte_o)
  );

endmodule

// ===== rtl/evbe_checker.sv =====
// ----------------------------------------------------------------------------
// Encoded value byte encoder: port checker
// Follows the result stream run by run and checks header and length rules.
// ----------------------------------------------------------------------------
`include "encoded_value_byte_encoder_macros.svh"

module evbe_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty_i,
  input logic       pop_i,
  input logic [7:0] out_byte_i,
  input logic       last_byte_i
);

  logic       hdr_expect_q;
  logic [2:0] arg_q;
  logic [2:0] cnt_q;
  logic       take;

  assign take = pop_i && !empty_i;

  // Track position within the current run
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_expect_q <= 1'b1;
      arg_q        <= '0;
      cnt_q        <= '0;
    end else if (take) begin
      hdr_expect_q <= last_byte_i;
      if (hdr_expect_q) begin
        arg_q <= out_byte_i[7:5];
        cnt_q <= '0;
      end else begin
        cnt_q <= cnt_q + 3'd1;
      end
    end
  end

  `EVBE_ASSERT_NEXT(a_hold_stalled, !empty_i && !pop_i, !empty_i && $stable(out_byte_i) && $stable(last_byte_i), "result changed while stalled")
  `EVBE_ASSERT_IMPL(a_single_hdr, !empty_i && hdr_expect_q && last_byte_i, out_byte_i[4:2] == 3'b111 && out_byte_i[7:6] == 2'b00, "lone header has bad kind or argument")
  `EVBE_ASSERT_IMPL(a_value_hdr, !empty_i && hdr_expect_q && !last_byte_i, out_byte_i[4:2] != 3'b111, "header-only kind followed by value bytes")
  `EVBE_ASSERT_IMPL(a_run_len, !empty_i && !hdr_expect_q && last_byte_i, cnt_q == arg_q, "value byte count differs from header")

endmodule

bind encoded_value_byte_encoder evbe_checker u_evbe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .empty_i     (empty),
  .pop_i       (pop),
  .out_byte_i  (out_byte_o),
  .last_byte_i (last_byte_o)
);

// ===== dv/encoded_value_byte_encoder_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Encoded value byte encoder: testbench
// Sends typed values through the push side with random gaps and checks every
// byte and last flag on the pop side against a built-in encoding predictor.
// ----------------------------------------------------------------------------
module encoded_value_byte_encoder_test;
  import evbe_pkg::*;

  // Kind codes that the block drops without output
  localparam logic [KindW-1:0] KindUnusedLow = 5'd1;
  localparam logic [KindW-1:0] KindUnusedMid = 5'd5;
  localparam logic [KindW-1:0] KindUnusedTop = 5'd20;

  localparam int unsigned RandomValues = 153;
  localparam int unsigned HoldCycles   = 80;

  // How the byte count of a kind is derived
  typedef enum {LenSigned, LenUnsigned, LenFloat, HeaderOnly, NoOutput} len_rule_e;

  typedef struct {
    logic [KindW-1:0]  kind;
    logic [ValueW-1:0] bits;
    int unsigned       gap;
    bit                drain_first;
  } value_item_t;

  typedef struct {
    logic [ByteW-1:0] data;
    logic             last;
  } enc_byte_t;

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              push         = 1'b0;
  logic              full;
  logic [KindW-1:0]  kind_i       = '0;
  logic [ValueW-1:0] value_bits_i = '0;
  logic              empty;
  logic              pop          = 1'b0;
  logic [ByteW-1:0]  out_byte_o;
  logic              last_byte_o;

  value_item_t pending_values[$];
  enc_byte_t   encoded_bytes[$];

  logic        item_taken    = 1'b0;
  logic        byte_taken    = 1'b0;
  int unsigned bytes_checked = 0;
  int unsigned mismatches    = 0;
  int unsigned rx_wait       = 0;
  int unsigned long_hold     = 0;
  int unsigned holds_left    = 3;
  int unsigned next_hold_at  = 60;

  encoded_value_byte_encoder dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .kind_i       (kind_i),
    .value_bits_i (value_bits_i),
    .empty        (empty),
    .pop          (pop),
    .out_byte_o   (out_byte_o),
    .last_byte_o  (last_byte_o)
  );

  always #6 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatches++;
  endtask

  // Append the byte run that one value encodes to
  function automatic void encode_value(input logic [KindW-1:0] kind,
                                       input logic [ValueW-1:0] bits);
    logic [ValueW-1:0]        v;
    logic signed [ValueW-1:0] top;
    logic                     arg;
    len_rule_e                rule;
    int unsigned              len;
    int unsigned              total;
    int unsigned              first;
    enc_byte_t                eb;
    v     = bits;
    arg   = 1'b0;
    rule  = LenSigned;
    total = 8;
    first = 0;
    len   = 1;
    case (kind)
      KindByte:   v = {{56{bits[7]}}, bits[7:0]};
      KindShort:  v = {{48{bits[15]}}, bits[15:0]};
      KindChar: begin
        v = {48'd0, bits[15:0]};
        rule = LenUnsigned;
      end
      KindInt:    v = {{32{bits[31]}}, bits[31:0]};
      KindLong:   v = bits;
      KindFloat: begin
        v = {32'd0, bits[31:0]};
        total = 4;
        rule = LenFloat;
      end
      KindDouble: rule = LenFloat;
      KindArray, KindAnnotation, KindNull: rule = HeaderOnly;
      KindBoolean: begin
        rule = HeaderOnly;
        arg = bits[0];
      end
      default: begin
        v = {32'd0, bits[31:0]};
        rule = (kind >= KindIdxFirst && kind <= KindIdxLast) ? LenUnsigned : NoOutput;
      end
    endcase

    case (rule)
      LenSigned: begin
        // grow until the bits above the kept bytes are all sign copies
        top = $signed(v) >>> 7;
        while (len < 8 && top != '0 && top != '1) begin
          len++;
          top = $signed(v) >>> (8 * len - 1);
        end
      end
      LenUnsigned: begin
        while (len < 8 && (v >> (8 * len)) != '0) len++;
      end
      LenFloat: begin
        // drop low zero bytes, keep at least one
        len = total;
        while (len > 1 && v[8 * (total - len) +: 8] == '0) len--;
        first = total - len;
      end
      HeaderOnly: begin
        eb.data = {2'b00, arg, kind};
        eb.last = 1'b1;
        encoded_bytes.push_back(eb);
        return;
      end
      default: return;
    endcase

    eb.data = {3'(len - 1), kind};
    eb.last = 1'b0;
    encoded_bytes.push_back(eb);
    for (int unsigned i = 0; i < len; i++) begin
      eb.data = v[8 * (first + i) +: 8];
      eb.last = (i + 1 == len);
      encoded_bytes.push_back(eb);
    end
  endfunction

  task automatic add_value(input logic [KindW-1:0] kind, input logic [ValueW-1:0] bits,
                           input bit idle, input bit drain_first = 1'b0);
    value_item_t it;
    it.kind        = kind;
    it.bits        = bits;
    it.gap         = idle ? $urandom_range(0, 6) : 0;
    it.drain_first = drain_first;
    pending_values.push_back(it);
  endtask

  // Check each popped byte, predict each pushed value
  always @(posedge clk_i) begin : check_bytes
    enc_byte_t want;
    item_taken <= rst_ni && push && !full;
    byte_taken <= rst_ni && pop && !empty;
    if (rst_ni && pop && !empty) begin
      if (encoded_bytes.size() == 0) begin
        report_mismatch($sformatf("byte %02h/%0b with nothing expected",
                                  out_byte_o, last_byte_o));
      end else begin
        want = encoded_bytes.pop_front();
        if (out_byte_o !== want.data)
          report_mismatch($sformatf("out_byte %02h, expected %02h", out_byte_o, want.data));
        if (last_byte_o !== want.last)
          report_mismatch($sformatf("last_byte %0b, expected %0b on byte %02h",
                                    last_byte_o, want.last, want.data));
      end
      bytes_checked <= bytes_checked + 1;
    end
    if (rst_ni && push && !full) encode_value(kind_i, value_bits_i);
  end

  // Present pending values; hold each one until it is taken
  always @(negedge clk_i) begin : drive_values
    value_item_t nxt;
    if (rst_ni && !(push && !item_taken)) begin
      if (pending_values.size() == 0) begin
        push <= 1'b0;
      end else if (pending_values[0].gap != 0) begin
        push <= 1'b0;
        pending_values[0].gap = pending_values[0].gap - 1;
      end else if (pending_values[0].drain_first && encoded_bytes.size() != 0) begin
        push <= 1'b0;
      end else begin
        nxt = pending_values.pop_front();
        push <= 1'b1;
        kind_i <= nxt.kind;
        value_bits_i <= nxt.bits;
      end
    end
  end

  // Long receiver hold-off, started a few times as bytes come out
  always @(negedge clk_i) begin : hold_off_sink
    if (long_hold != 0) begin
      long_hold <= long_hold - 1;
    end else if (rst_ni && holds_left != 0 && bytes_checked >= next_hold_at) begin
      long_hold <= HoldCycles;
      holds_left <= holds_left - 1;
      next_hold_at <= next_hold_at + 300;
    end
  end

  // Pop bytes with a random wait drawn after each transaction
  always @(negedge clk_i) begin : drive_pop
    int unsigned w;
    bit          rx_idle;
    rx_idle = ((bytes_checked / 120) % 3) != 1;
    w = byte_taken ? (rx_idle ? $urandom_range(0, 6) : 0) : rx_wait;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (long_hold != 0) begin
      pop <= 1'b0;
      rx_wait <= w;
    end else if (w != 0) begin
      pop <= 1'b0;
      rx_wait <= w - 1;
    end else begin
      pop <= 1'b1;
      rx_wait <= 0;
    end
  end

  initial begin : stimulus
    logic [KindW-1:0]  k;
    logic [ValueW-1:0] raw;
    int unsigned       sh;
    bit                idle;

    // Extremes and special cases
    add_value(KindByte, 64'h7f, 1'b1);
    add_value(KindByte, 64'hffff_ffff_ffff_ff80, 1'b1);
    add_value(KindShort, 64'h8000, 1'b1);
    add_value(KindShort, 64'h0080, 1'b1);
    add_value(KindChar, 64'hffff, 1'b1);
    add_value(KindChar, 64'hffff_ffff_ffff_0000, 1'b1);
    add_value(KindInt, 64'h7fff_ffff, 1'b1);
    add_value(KindInt, 64'hffff_ffff_ffff_ff80, 1'b1);
    add_value(KindLong, 64'h7fff_ffff_ffff_ffff, 1'b0);
    add_value(KindLong, 64'h8000_0000_0000_0000, 1'b0);
    add_value(KindLong, 64'h0000_0000_8000_0000, 1'b0);
    add_value(KindLong, 64'hffff_ffff_ffff_ffff, 1'b0);
    add_value(KindFloat, 64'h0, 1'b1);
    add_value(KindFloat, 64'h3f80_0000, 1'b1);
    add_value(KindFloat, 64'hffff_ffff_0000_0001, 1'b1);
    add_value(KindDouble, 64'h0, 1'b1);
    add_value(KindDouble, 64'h3ff0_0000_0000_0000, 1'b1);
    add_value(KindDouble, 64'hffff_ffff_ffff_ffff, 1'b1);
    add_value(KindIdxFirst, 64'hffff_ffff_ffff_ffff, 1'b1);
    add_value(KindIdxLast, 64'h0, 1'b1);
    add_value(KindArray, 64'h0, 1'b1);
    add_value(KindAnnotation, 64'hffff_ffff_ffff_ffff, 1'b1);
    add_value(KindNull, 64'h0, 1'b1, 1'b1);
    add_value(KindBoolean, 64'h0, 1'b1);
    add_value(KindBoolean, 64'hffff_ffff_ffff_ffff, 1'b1);
    add_value(KindUnusedLow, 64'h1234, 1'b1);
    add_value(KindUnusedTop, 64'hffff_ffff_ffff_ffff, 1'b1);

    // Random values: mostly known kinds, lengths spread by shifting
    for (int unsigned n = 0; n < RandomValues; n++) begin
      idle = ((n / 40) % 3) != 2;
      if ($urandom_range(0, 99) < 8) begin
        k = KindW'($urandom_range(7, 20));
        if (k == KindFloat) k = KindUnusedLow;
        if (k == KindDouble) k = KindUnusedMid;
      end else begin
        case ($urandom_range(0, 11))
          0: k = KindByte;
          1: k = KindShort;
          2: k = KindChar;
          3: k = KindInt;
          4: k = KindLong;
          5: k = KindFloat;
          6: k = KindDouble;
          7: k = KindW'($urandom_range(KindIdxFirst, KindIdxLast));
          8: k = KindArray;
          9: k = KindAnnotation;
          10: k = KindNull;
          default: k = KindBoolean;
        endcase
      end
      raw = {$urandom, $urandom};
      sh = $urandom_range(0, 63);
      case ($urandom_range(0, 3))
        0: raw = raw;
        1: raw = raw >> sh;
        2: raw = ~(raw >> sh);
        default: raw = raw << sh;
      endcase
      add_value(k, raw, idle, n == 60 || n == 150);
    end

    // Reset, then let the processes run until everything drains
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    while (pending_values.size() != 0 || push) @(posedge clk_i);
    while (encoded_bytes.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("encoded_value_byte_encoder_test: PASS");
    end else begin
      $display("encoded_value_byte_encoder_test: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #1_500_000;
    $display("encoded_value_byte_encoder_test: FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/evbe_pkg.sv
rtl/evbe_front.sv
rtl/evbe_queue.sv
rtl/evbe_back.sv
rtl/encoded_value_byte_encoder.sv
rtl/evbe_checker.sv
dv/encoded_value_byte_encoder_test.sv
